### rtl/core/fiqt_pkg.sv
package fiqt_pkg;

    localparam int STORE_DEPTH = 2048;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = AW + 1;
    localparam int TB = 48;
    localparam int RW = 19;
    localparam logic [RW-1:0] RATE_MAX = {RW{1'b1}};
    localparam logic [TB-1:0] RATE_NUM = 48'd256000000000;
    localparam int DIVN = 38;

    // p*n/100 as (n * p*ceil(2^25/100)) >> 25, exact for n up to the store depth
    localparam int QSH = 25;
    localparam logic [25:0] Q50_K = 26'd16777250;
    localparam logic [25:0] Q95_K = 26'd31876775;
    localparam logic [25:0] Q99_K = 26'd33218955;

    localparam logic [2:0] REG_DEFAULT = 3'd0;
    localparam logic [2:0] REG_MIN = 3'd1;
    localparam logic [2:0] REG_WARM = 3'd2;
    localparam logic [2:0] REG_PERIOD = 3'd3;
    localparam logic [2:0] REG_LIMIT = 3'd4;

    localparam logic CMD_START = 1'b0;

    typedef struct packed {
        logic          command;
        logic [TB-1:0] timestamp_ns;
    } t_in;

    typedef struct packed {
        logic          updated;
        logic [RW-1:0] fps_median;
        logic [RW-1:0] fps_p95;
        logic [RW-1:0] fps_p99;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_MOD,
        S_QRD,
        S_QCAP,
        S_HRD,
        S_HWR,
        S_DIV,
        S_OUT
    } t_state;

endpackage

### rtl/core/frame_interval_quantile_tracker.sv
// Frame interval quantile tracker. Each beat on the input channel is a start
// or frame command with a timestamp; each yields one result beat carrying the
// 50/95/99 percentile rates as unsigned Q.8 fps and an updated flag. Intervals
// are kept sorted in a single-port store by an insertion walk that reads, then
// writes, one entry at a time. A frame that stores an interval walks the
// shifted entries and then checks the new count against the sort period; when
// the quantiles change it adds store reads, a halving pass when the store has
// reached the limit, and the three bit-serial rate divisions. A start runs the
// divisions; other frames give their result the next cycle. Output stalls add.
module frame_interval_quantile_tracker
    import fiqt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_default, r_min;
    logic [7:0]  r_warm, r_seen;
    logic [10:0] r_period, r_limit;
    logic [TB-1:0] r_last, r_val, r_rd;
    logic [CW-1:0] r_cnt, r_idx, r_n, r_half, r_dvd;
    logic [TB-1:0] r_q [3];
    logic [RW-1:0] r_rate [3];
    logic [1:0]  r_qi;
    logic        r_upd;
    t_state      r_st, n_st;
    logic [TB-1:0] mem [STORE_DEPTH];

    logic [TB-1:0] r_rem;
    logic [DIVN-1:0] r_quo;
    logic [5:0]  r_bit;

    logic        acc_in, acc_out, wr_cfg;
    logic        we;
    logic [AW-1:0] addr;
    logic [TB-1:0] wdata;
    logic [CW+25:0] qprod;
    logic [AW-1:0] qaddr;
    logic [10:0] per;
    logic [TB-1:0] delta;
    logic        short_iv, warming, store_go, shift_go;
    logic [CW-1:0] mtry;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;
    assign acc_in = i_valid && !o_stall;
    assign acc_out = o_valid && !i_stall;
    assign per = (r_period == 11'd0) ? 11'd1 : r_period;

    assign delta = i_data.timestamp_ns - r_last;
    assign short_iv = delta < TB'(r_min);
    assign warming = r_seen < r_warm;
    assign store_go = !short_iv && !warming && (r_cnt < CW'(STORE_DEPTH));
    assign shift_go = (r_idx != '0) && (r_rd > r_val);
    assign mtry = {r_rem[CW-2:0], r_dvd[CW-1]};

    always_comb begin
        o_stall = (r_st != S_IDLE);
        o_valid = (r_st == S_OUT);
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_DEFAULT: prdata = r_default;
            REG_MIN:     prdata = r_min;
            REG_WARM:    prdata = {24'd0, r_warm};
            REG_PERIOD:  prdata = {21'd0, r_period};
            REG_LIMIT:   prdata = {21'd0, r_limit};
            default:     prdata = 32'd0;
        endcase
    end

    always_comb begin
        unique case (r_qi)
            2'd0:    qprod = r_n * Q50_K;
            2'd1:    qprod = r_n * Q95_K;
            default: qprod = r_n * Q99_K;
        endcase
    end

    assign qaddr = qprod[QSH +: AW];

    always_comb begin
        we = 1'b0;
        addr = r_idx[AW-1:0];
        wdata = r_rd;
        unique case (r_st)
            S_RD: addr = AW'(r_idx - 1'b1);
            S_CMP: begin
                we = 1'b1;
                if (shift_go) wdata = r_rd;
                else wdata = r_val;
            end
            S_QRD: addr = qaddr;
            S_HRD: addr = AW'(r_half + r_idx);
            S_HWR: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[addr] <= wdata;
        r_rd <= mem[addr];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (acc_in) begin
                if (i_data.command == CMD_START) n_st = S_DIV;
                else if (store_go) n_st = S_RD;
                else n_st = S_OUT;
            end
            S_RD:   n_st = S_CMP;
            S_CMP:  n_st = shift_go ? S_RD : S_MOD;
            S_MOD:  if (r_bit == 6'd0) n_st = (r_rem == '0) ? S_QRD : S_OUT;
            S_QRD:  n_st = S_QCAP;
            S_QCAP: n_st = (r_qi != 2'd2) ? S_QRD :
                           (r_n >= CW'(r_limit)) ? S_HRD : S_DIV;
            S_HRD:  n_st = (r_idx < r_half) ? S_HWR : S_DIV;
            S_HWR:  n_st = S_HRD;
            S_DIV:  n_st = (r_bit == 6'd0 && r_qi == 2'd2) ? S_OUT : S_DIV;
            S_OUT:  if (acc_out) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_default <= 32'd33333333;
            r_min <= 32'd500000;
            r_warm <= 8'd10;
            r_period <= 11'd100;
            r_limit <= 11'd1000;
            r_last <= '0;
            r_seen <= '0;
            r_cnt <= '0;
            for (int k = 0; k < 3; k++) r_q[k] <= TB'(33333333);
            for (int k = 0; k < 3; k++) r_rate[k] <= 19'd7680;
        end else begin
            r_st <= n_st;
            if (wr_cfg) begin
                unique case (paddr[4:2])
                    REG_DEFAULT: r_default <= pwdata;
                    REG_MIN:     r_min <= pwdata;
                    REG_WARM:    r_warm <= pwdata[7:0];
                    REG_PERIOD:  r_period <= pwdata[10:0];
                    REG_LIMIT:   r_limit <= pwdata[10:0];
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: if (acc_in) begin
                    r_upd <= 1'b0;
                    r_qi <= 2'd0;
                    r_bit <= 6'(DIVN);
                    r_last <= i_data.timestamp_ns;
                    r_rem <= '0;
                    if (i_data.command == CMD_START) begin
                        r_cnt <= '0;
                        r_seen <= '0;
                        for (int k = 0; k < 3; k++) r_q[k] <= TB'(r_default);
                    end else begin
                        r_val <= delta;
                        r_idx <= r_cnt;
                        if (!short_iv && warming) r_seen <= r_seen + 1'b1;
                    end
                end
                S_RD: ;
                S_CMP: begin
                    if (shift_go) r_idx <= r_idx - 1'b1;
                    else begin
                        r_n <= r_cnt + 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                        r_dvd <= r_cnt + 1'b1;
                        r_bit <= 6'(CW);
                        r_rem <= '0;
                    end
                end
                // remainder of the new count by the sort period
                S_MOD: begin
                    if (r_bit == 6'd0) begin
                        r_bit <= 6'(DIVN);
                        r_rem <= '0;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                        r_dvd <= {r_dvd[CW-2:0], 1'b0};
                        r_rem <= (mtry >= CW'(per)) ? TB'(mtry - CW'(per)) : TB'(mtry);
                    end
                end
                S_QRD: ;
                S_QCAP: begin
                    r_q[r_qi] <= r_rd;
                    r_upd <= 1'b1;
                    if (r_qi != 2'd2) r_qi <= r_qi + 1'b1;
                    else begin
                        r_qi <= 2'd0;
                        r_half <= r_n >> 1;
                        r_idx <= CW'(1);
                        if (r_n >= CW'(r_limit)) r_cnt <= r_n >> 1;
                    end
                end
                S_HRD: ;
                S_HWR: r_idx <= r_idx + 2'd2;
                S_DIV: begin
                    if (r_bit == 6'd0) begin
                        r_rate[r_qi] <= (r_q[r_qi] == 0 || r_quo > DIVN'(RATE_MAX))
                                        ? RATE_MAX : RW'(r_quo);
                        r_bit <= 6'(DIVN);
                        r_rem <= '0;
                        if (r_qi != 2'd2) r_qi <= r_qi + 1'b1;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                        if ({r_rem[TB-2:0], RATE_NUM[r_bit-1]} >= r_q[r_qi]) begin
                            r_rem <= {r_rem[TB-2:0], RATE_NUM[r_bit-1]} - r_q[r_qi];
                            r_quo <= {r_quo[DIVN-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[TB-2:0], RATE_NUM[r_bit-1]};
                            r_quo <= {r_quo[DIVN-2:0], 1'b0};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_data.updated = r_upd;
    assign o_data.fps_median = r_rate[0];
    assign o_data.fps_p95 = r_rate[1];
    assign o_data.fps_p99 = r_rate[2];

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result without busy");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STORE_DEPTH)) else $error("count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result lost");

endmodule

### verif/fiqt_checker.sv
module fiqt_checker
    import fiqt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  t_in         in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  t_out        out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);

    logic [31:0] cfg_default, cfg_min;
    logic [7:0]  cfg_warm;
    logic [10:0] cfg_period, cfg_limit;

    logic [TB-1:0] last_ts;
    int unsigned   warm_seen, n_stored;
    logic [TB-1:0] intervals [STORE_DEPTH];
    logic [TB-1:0] q_iv [3];
    t_out          expected_beats [$];

    function automatic logic [RW-1:0] rate_of(logic [TB-1:0] iv);
        logic [63:0] q;
        if (iv == 0) return RATE_MAX;
        q = 64'd256000000000 / {16'd0, iv};
        return (q > 64'(RATE_MAX)) ? RATE_MAX : q[RW-1:0];
    endfunction

    function automatic logic track_frame(logic [TB-1:0] ts);
        logic [TB-1:0] d;
        int unsigned per, i, half;
        d = ts - last_ts;
        per = (cfg_period == 0) ? 1 : cfg_period;
        last_ts = ts;
        if (d < {16'd0, cfg_min}) return 1'b0;
        if (warm_seen < cfg_warm) begin
            warm_seen++;
            return 1'b0;
        end
        if (n_stored >= STORE_DEPTH) return 1'b0;
        i = n_stored;
        while (i > 0 && intervals[i-1] > d) begin
            intervals[i] = intervals[i-1];
            i--;
        end
        intervals[i] = d;
        n_stored++;
        if (n_stored % per != 0) return 1'b0;
        q_iv[0] = intervals[(50 * n_stored) / 100];
        q_iv[1] = intervals[(95 * n_stored) / 100];
        q_iv[2] = intervals[(99 * n_stored) / 100];
        if (n_stored >= cfg_limit) begin
            half = n_stored / 2;
            for (i = 1; i < half; i += 2) intervals[i] = intervals[half + i];
            n_stored = half;
        end
        return 1'b1;
    endfunction

    assign pending = expected_beats.size();

    always @(posedge i_clk) begin
        t_out e, got;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg_default <= 32'd33333333;
            cfg_min <= 32'd500000;
            cfg_warm <= 8'd10;
            cfg_period <= 11'd100;
            cfg_limit <= 11'd1000;
            last_ts = '0;
            warm_seen = 0;
            n_stored = 0;
            for (int k = 0; k < 3; k++) q_iv[k] = 48'd33333333;
            expected_beats.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_DEFAULT: cfg_default <= pwdata;
                    REG_MIN:     cfg_min <= pwdata;
                    REG_WARM:    cfg_warm <= pwdata[7:0];
                    REG_PERIOD:  cfg_period <= pwdata[10:0];
                    REG_LIMIT:   cfg_limit <= pwdata[10:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                e.updated = 1'b0;
                if (in_data.command == CMD_START) begin
                    n_stored = 0;
                    warm_seen = 0;
                    for (int k = 0; k < 3; k++) q_iv[k] = {16'd0, cfg_default};
                    last_ts = in_data.timestamp_ns;
                end else begin
                    e.updated = track_frame(in_data.timestamp_ns);
                end
                e.fps_median = rate_of(q_iv[0]);
                e.fps_p95 = rate_of(q_iv[1]);
                e.fps_p99 = rate_of(q_iv[2]);
                expected_beats = {expected_beats, e};
            end
            if (out_valid && !out_stall) begin
                got = out_data;
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat %p", got);
                    errs++;
                end else begin
                    e = expected_beats.pop_front();
                    if (got.updated !== e.updated) begin
                        $error("updated: expected %0d actual %0d", e.updated, got.updated);
                        errs++;
                    end
                    if (got.fps_median !== e.fps_median) begin
                        $error("fps_median: expected %0d actual %0d",
                               e.fps_median, got.fps_median);
                        errs++;
                    end
                    if (got.fps_p95 !== e.fps_p95) begin
                        $error("fps_p95: expected %0d actual %0d", e.fps_p95, got.fps_p95);
                        errs++;
                    end
                    if (got.fps_p99 !== e.fps_p99) begin
                        $error("fps_p99: expected %0d actual %0d", e.fps_p99, got.fps_p99);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

### verif/tb_frame_interval_quantile_tracker.sv
module tb_frame_interval_quantile_tracker;
    import fiqt_pkg::*;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall, o_valid, i_stall;
    t_in         i_data;
    t_out        o_data;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending;
    int          idle_cycles;
    logic [TB-1:0] now_ns;

    localparam int IDLE_LIMIT = 200000;

    frame_interval_quantile_tracker dut (.*);

    fiqt_checker checker_i (
        .i_clk, .i_rst_n,
        .in_valid(i_valid), .in_stall(o_stall), .in_data(i_data),
        .out_valid(o_valid), .out_stall(i_stall), .out_data(o_data),
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .fail_count, .pending
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    initial begin
        int g;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    i_stall <= 1'b1;
                    repeat (g) @(negedge i_clk);
                end
            end
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_frame_interval_quantile_tracker failed");
            $finish;
        end
    end

    // valid stays high into the next beat unless a gap follows
    task automatic send_beat(logic cmd, logic [TB-1:0] ts);
        int g;
        g = ($urandom_range(0, 4) == 0) ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{command: cmd, timestamp_ns: ts};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic frame_after(logic [TB-1:0] dt);
        now_ns = now_ns + dt;
        send_beat(1'b1, now_ns);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(int count, logic [TB-1:0] lo, logic [TB-1:0] hi);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                now_ns = TB'({$urandom, $urandom});
                send_beat(CMD_START, now_ns);
            end else if (r < 8) begin
                frame_after(TB'({$urandom, $urandom}));
            end else if (r < 12) begin
                frame_after(TB'($urandom_range(0, 600000)));
            end else begin
                frame_after(TB'(lo + ({$urandom, $urandom} % (hi - lo + 1))));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        now_ns = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: defaults, wrap, zero and huge intervals, warm-up
        send_beat(1'b1, 48'd1000000);
        send_beat(CMD_START, 48'hFFFF_FFFF_F000);
        now_ns = 48'hFFFF_FFFF_F000;
        frame_after(48'd40000000);
        frame_after(48'd100);
        drain();
        reg_write(REG_DEFAULT, 32'hFFFF_FFFF);
        reg_write(REG_MIN, 32'd0);
        reg_write(REG_WARM, 32'd2);
        reg_write(REG_PERIOD, 32'd0);
        reg_write(REG_LIMIT, 32'd2);
        send_beat(CMD_START, now_ns);
        frame_after(48'd0);
        frame_after(48'd1);
        frame_after(48'd0);
        frame_after(48'd400000);
        frame_after(48'hFFFF_FFFF_FFFF);
        frame_after(48'd488281);
        frame_after(48'd488282);
        frame_after(48'h8000_0000_0000);
        drain();
        reg_write(REG_WARM, 32'd255);
        reg_write(REG_PERIOD, 32'd1);
        reg_write(REG_LIMIT, 32'd1024);
        frame_after(48'd5);
        frame_after(48'd7);
        drain();
        reg_write(REG_WARM, 32'd0);
        frame_after(48'd9);
        frame_after(48'd3);
        drain();

        // random phases
        reg_write(REG_DEFAULT, 32'd500000);
        reg_write(REG_MIN, 32'd500000);
        reg_write(REG_WARM, 32'd3);
        reg_write(REG_PERIOD, 32'd4);
        reg_write(REG_LIMIT, 32'd16);
        send_beat(CMD_START, now_ns);
        run_phase(50, 48'd500000, 48'd50000000);
        drain();
        reg_write(REG_MIN, 32'hFFFF_FFFF);
        reg_write(REG_PERIOD, 32'd1024);
        run_phase(10, 48'd1, 48'hFFFF_FFFF);
        drain();
        reg_write(REG_DEFAULT, $urandom_range(500000, 32'hFFFF_FFFF));
        reg_write(REG_MIN, 32'd1000);
        reg_write(REG_WARM, 32'd1);
        reg_write(REG_PERIOD, 32'd3);
        reg_write(REG_LIMIT, 32'd10);
        send_beat(CMD_START, now_ns);
        run_phase(60, 48'd1000, 48'd2000000000);

        drain();
        if (fail_count == 0)
            $display("tb_frame_interval_quantile_tracker passed");
        else
            $display("tb_frame_interval_quantile_tracker failed");
        $finish;
    end

endmodule
